@@ design/tfv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tfv_pkg;

  // Big-endian tags as they sit in the byte window, newest byte lowest
  localparam logic [31:0] TAG_HDR_START = 32'hCAFE_DADE;
  localparam logic [31:0] TAG_DAT_START = 32'hCAFE_BABE;
  localparam logic [31:0] TAG_HDR_END   = 32'hDADE_CAFE;
  localparam logic [31:0] TAG_DAT_END   = 32'hBABE_CAFE;

  localparam logic [7:0] HDR_LEN      = 8'd18;
  localparam logic [7:0] DAT_BASE     = 8'd16;
  localparam logic [7:0] TAG_BYTES    = 8'd4;
  localparam logic [7:0] CNT_HIGH_POS = 8'd11;
  localparam logic [7:0] CNT_LOW_POS  = 8'd12;

  typedef enum logic [2:0] {
    VERDICT_OK         = 3'd0,
    VERDICT_NO_END     = 3'd1,
    VERDICT_BAD_SIZE   = 3'd2,
    VERDICT_INCOMPLETE = 3'd3
  } verdict_t;

  typedef struct packed {
    logic     frame_kind;
    verdict_t verdict;
    logic [7:0] frame_bytes;
  } result_t;

endpackage
`default_nettype wire

@@ design/tagged_frame_validator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Ports                                          Carries
// in_      input      in_valid, in_ready, in_byte_value,            one stream byte
//                     in_buffer_end                                  per transaction
// out_     output     out_valid, out_ready, out_frame_kind,         one frame verdict
//                     out_verdict, out_frame_bytes                   per transaction
//
// One byte per cycle sustained while the result buffer has space: window shift, tag
// compare, byte counter and length multiply all settle combinationally between the
// input register and the result buffer, from which each registered verdict is presented.
// rst_n is synchronous and active low; it restores hunting mode with a clear window.
// A two-entry result buffer absorbs a stalled consumer; input stalls only once it is full.
module tagged_frame_validator #(
  parameter int CHANNEL_BYTES   = 8,
  parameter int MAX_FRAME_BYTES = 208
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] in_byte_value,
  input  wire logic       in_buffer_end,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic       out_frame_kind,
  output      logic [2:0] out_verdict,
  output      logic [7:0] out_frame_bytes
);
  import tfv_pkg::*;

  logic    space;
  logic    push;
  result_t push_data;
  result_t out_data;

  // Register each byte, track the frame and decide the verdict
  tfv_core #(
    .CHANNEL_BYTES  (CHANNEL_BYTES),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte_value(in_byte_value),
    .in_buffer_end(in_buffer_end),
    .space        (space),
    .push         (push),
    .push_data    (push_data)
  );

  // Hold verdicts until the consumer takes the transaction
  tfv_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .space    (space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign out_frame_kind  = out_data.frame_kind;
  assign out_verdict     = 3'(out_data.verdict);
  assign out_frame_bytes = out_data.frame_bytes;

endmodule
`default_nettype wire

@@ design/tfv_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tfv_core #(
  parameter int CHANNEL_BYTES   = 8,
  parameter int MAX_FRAME_BYTES = 208
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire logic [7:0]      in_byte_value,
  input  wire logic            in_buffer_end,
  input  wire logic            space,
  output      logic            push,
  output      tfv_pkg::result_t push_data
);
  import tfv_pkg::*;

  localparam int LEN_W = 16 + $clog2(CHANNEL_BYTES) + 2;

  // Input register
  logic       stage_valid_r, stage_valid_nxt;
  logic [7:0] stage_byte_r;
  logic       stage_last_r;

  // Frame tracking state
  logic [31:0] window_r, window_nxt;
  logic        hunting_r, hunting_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  expected_r, expected_nxt;
  logic [7:0]  count_high_r, count_high_nxt;

  logic             advance;
  logic [31:0]      shifted;
  logic [7:0]       cnt_inc;
  logic [7:0]       exp_eff;
  logic [15:0]      chan_count;
  logic [LEN_W-1:0] data_len;
  logic             emit;
  result_t          res;

  assign advance  = stage_valid_r && space;
  assign in_ready = !stage_valid_r || advance;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (advance) stage_valid_nxt = 1'b0;
    if (in_valid && in_ready) stage_valid_nxt = 1'b1;
  end

  assign shifted    = {window_r[23:0], stage_byte_r};
  assign cnt_inc    = count_r + 8'd1;
  assign chan_count = {count_high_r, stage_byte_r};
  assign data_len   = LEN_W'(chan_count) * LEN_W'(CHANNEL_BYTES) + LEN_W'(DAT_BASE);

  always_comb begin
    window_nxt     = shifted;
    hunting_nxt    = hunting_r;
    kind_nxt       = kind_r;
    count_nxt      = count_r;
    expected_nxt   = expected_r;
    count_high_nxt = count_high_r;
    exp_eff        = expected_r;
    emit           = 1'b0;
    res.frame_kind  = kind_r;
    res.verdict     = VERDICT_OK;
    res.frame_bytes = 8'd0;

    if (hunting_r) begin
      if (shifted == TAG_HDR_START || shifted == TAG_DAT_START) begin
        hunting_nxt    = 1'b0;
        kind_nxt       = (shifted == TAG_DAT_START);
        count_nxt      = TAG_BYTES;
        expected_nxt   = (shifted == TAG_DAT_START) ? 8'd0 : HDR_LEN;
        count_high_nxt = 8'd0;
        if (stage_last_r) begin
          emit            = 1'b1;
          res.frame_kind  = kind_nxt;
          res.verdict     = VERDICT_INCOMPLETE;
          res.frame_bytes = expected_nxt;
        end
      end else if (stage_last_r) begin
        window_nxt = 32'd0;
      end
    end else begin
      count_nxt = cnt_inc;
      if (kind_r && expected_r == 8'd0) begin
        if (cnt_inc == CNT_HIGH_POS) begin
          count_high_nxt = stage_byte_r;
        end else if (cnt_inc == CNT_LOW_POS) begin
          if (data_len > LEN_W'(MAX_FRAME_BYTES)) begin
            emit            = 1'b1;
            res.frame_kind  = 1'b1;
            res.verdict     = VERDICT_BAD_SIZE;
            res.frame_bytes = 8'd0;
          end else begin
            exp_eff      = data_len[7:0];
            expected_nxt = exp_eff;
          end
        end
      end
      if (!emit) begin
        if (exp_eff != 8'd0 && cnt_inc >= exp_eff) begin
          emit            = 1'b1;
          res.verdict     = (shifted == (kind_r ? TAG_DAT_END : TAG_HDR_END)) ?
                            VERDICT_OK : VERDICT_NO_END;
          res.frame_bytes = exp_eff;
        end else if (stage_last_r) begin
          emit            = 1'b1;
          res.verdict     = VERDICT_INCOMPLETE;
          res.frame_bytes = exp_eff;
        end
      end
    end

    // A verdict closes the frame: clear and hunt again
    if (emit) begin
      window_nxt     = 32'd0;
      hunting_nxt    = 1'b1;
      count_nxt      = 8'd0;
      expected_nxt   = 8'd0;
      count_high_nxt = 8'd0;
    end
  end

  assign push      = advance && emit;
  assign push_data = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      window_r      <= 32'd0;
      hunting_r     <= 1'b1;
      kind_r        <= 1'b0;
      count_r       <= 8'd0;
      expected_r    <= 8'd0;
      count_high_r  <= 8'd0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      if (advance) begin
        window_r     <= window_nxt;
        hunting_r    <= hunting_nxt;
        kind_r       <= kind_nxt;
        count_r      <= count_nxt;
        expected_r   <= expected_nxt;
        count_high_r <= count_high_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte_r <= in_byte_value;
      stage_last_r <= in_buffer_end;
    end
  end

endmodule
`default_nettype wire

@@ design/tfv_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tfv_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire tfv_pkg::result_t push_data,
  output      logic             space,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      tfv_pkg::result_t out_data
);
  import tfv_pkg::*;

  logic [1:0] fill_r, fill_nxt;
  result_t    slot0_r, slot1_r;
  logic       pop;

  assign out_valid = (fill_r != 2'd0);
  assign out_data  = slot0_r;
  assign space     = (fill_r != 2'd2);
  assign pop       = out_valid && out_ready;

  always_comb begin
    fill_nxt = fill_r;
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + 2'd1;
      2'b01:   fill_nxt = fill_r - 2'd1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Head slot always drives the port; second slot absorbs a stalled consumer
  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (fill_r == 2'd0) slot0_r <= push_data;
        else                slot1_r <= push_data;
      end
      2'b01: slot0_r <= slot1_r;
      2'b11: begin
        if (fill_r == 2'd1) begin
          slot0_r <= push_data;
        end else begin
          slot0_r <= slot1_r;
          slot1_r <= push_data;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
